// ----- rtl/core/pts_pkg.sv -----
// shared types and constants for the priority task scheduler
package pts_pkg;

  localparam int PTS_PRIO_LEVELS = 8;
  localparam int PTS_DELAY_BITS  = 32;
  localparam logic [15:0] MIN_STACK_RST = 16'd256;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_DELETE = 3'd1,
    OP_PEND   = 3'd2,
    OP_READY  = 3'd3,
    OP_DELAY  = 3'd4,
    OP_TICK   = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    RC_OK      = 3'd0,
    RC_STACK   = 3'd1,
    RC_IDLE    = 3'd2,
    RC_READY   = 3'd3,
    RC_UNKNOWN = 3'd4,
    RC_UNUSED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_PEND    = 2'd1,
    TS_UNKNOWN = 2'd2
  } tstat_t;

  typedef enum logic [1:0] {
    BK_NONE  = 2'd0,
    BK_LOAD  = 2'd1,
    BK_CLEAR = 2'd2,
    BK_DEC   = 2'd3
  } bank_op_t;

endpackage

// ----- rtl/core/pts_ifs.sv -----
// request and result channel interfaces of the scheduler
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  task_prio;
  logic [1:0]  initial_state;
  logic [15:0] stack_bytes;
  logic [31:0] delay_ticks;

  modport source (output valid, opcode, task_prio, initial_state, stack_bytes, delay_ticks,
                  input ready);
  modport sink (input valid, opcode, task_prio, initial_state, stack_bytes, delay_ticks,
                output ready);
endinterface

interface pts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status_code;
  logic [2:0] current_prio;
  logic [7:0] ready_bits;

  modport source (output valid, status_code, current_prio, ready_bits, input ready);
  modport sink (input valid, status_code, current_prio, ready_bits, output ready);
endinterface

// ----- rtl/core/pts_delay_bank.sv -----
// per-level delay counters with one shared decrementer
module pts_delay_bank import pts_pkg::*; #(
  parameter int PRIO_LEVELS = PTS_PRIO_LEVELS,
  parameter int DELAY_BITS  = PTS_DELAY_BITS,
  localparam int LVL_W = $clog2(PRIO_LEVELS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bank_op_t              op,
  input  logic [LVL_W-1:0]      idx,
  input  logic [DELAY_BITS-1:0] load_val,
  output logic                  dec_zero
);

  logic [DELAY_BITS-1:0] delay_r [PRIO_LEVELS];
  logic [DELAY_BITS-1:0] dec_val;

  // a zero count wraps to all ones
  assign dec_val  = delay_r[idx] - DELAY_BITS'(1);
  assign dec_zero = (dec_val == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PRIO_LEVELS; i++) begin
        delay_r[i] <= '0;
      end
    end else begin
      case (op)
        BK_LOAD:  delay_r[idx] <= load_val;
        BK_CLEAR: delay_r[idx] <= '0;
        BK_DEC:   delay_r[idx] <= dec_val;
        default:  ;
      endcase
    end
  end

endmodule

// ----- rtl/core/priority_task_scheduler.sv -----
// top level: bitmap priority scheduler with a stepping sequencer
// sequence: accept, decode, a level walk, then the result is loaded
// create and errors skip the level walk; delete/pend/ready/delay walk the bitmap
// tick: the one-level-a-cycle counter walk, then the top-down bitmap scan,
// both sharing one level counter
// one request at a time; synchronous active-low reset, all tasks unknown, idle runs
module priority_task_scheduler import pts_pkg::*; #(
  parameter int PRIO_LEVELS = PTS_PRIO_LEVELS,
  parameter int DELAY_BITS  = PTS_DELAY_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  pts_in_if.sink      in_req,
  pts_out_if.source   out_rsp
);

  localparam int LVL_W = $clog2(PRIO_LEVELS);
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(PRIO_LEVELS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_SCHED,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  tstat_t                 status_r [PRIO_LEVELS];
  tstat_t                 status_nxt [PRIO_LEVELS];
  logic [PRIO_LEVELS-1:0] list_r, list_nxt;
  logic [PRIO_LEVELS-1:0] mask_r, mask_nxt;
  logic [LVL_W-1:0]       run_r, run_nxt;
  logic [LVL_W-1:0]       idx_r, idx_nxt;
  logic [15:0]            min_stack_r;
  status_t                rc_r, rc_nxt;

  opcode_t                op_r;
  logic [2:0]             prio_r;
  logic [1:0]             init_r;
  logic [15:0]            stack_r;
  logic [DELAY_BITS-1:0]  ticks_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_code_r, out_code_nxt;
  logic [2:0]             out_prio_r, out_prio_nxt;
  logic [7:0]             out_bits_r, out_bits_nxt;

  bank_op_t               bank_op;
  logic [LVL_W-1:0]       bank_idx;
  logic                   bank_zero;

  logic [5:0]             p_ext;
  logic                   p_valid;
  logic [LVL_W-1:0]       p_idx;
  tstat_t                 init_st;
  logic                   accept;

  assign accept  = in_req.valid && in_req.ready;
  assign p_ext   = {3'b000, prio_r};
  assign p_valid = (p_ext < 6'(PRIO_LEVELS));
  assign p_idx   = LVL_W'(p_ext);
  assign init_st = (init_r > 2'(TS_UNKNOWN)) ? TS_UNKNOWN : tstat_t'(init_r);

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status_code = out_code_r;
  assign out_rsp.current_prio = out_prio_r;
  assign out_rsp.ready_bits  = out_bits_r;

  pts_delay_bank #(
    .PRIO_LEVELS (PRIO_LEVELS),
    .DELAY_BITS  (DELAY_BITS)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (bank_op),
    .idx      (bank_idx),
    .load_val (ticks_r),
    .dec_zero (bank_zero)
  );

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    list_nxt      = list_r;
    mask_nxt      = mask_r;
    run_nxt       = run_r;
    idx_nxt       = idx_r;
    rc_nxt        = rc_r;
    bank_op       = BK_NONE;
    bank_idx      = idx_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_code_nxt  = out_code_r;
    out_prio_nxt  = out_prio_r;
    out_bits_nxt  = out_bits_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        rc_nxt    = RC_OK;
        idx_nxt   = TOP_LVL;
        state_nxt = S_SCHED;
        bank_idx  = p_idx;
        unique case (op_r)
          OP_CREATE: begin
            state_nxt = S_DONE;
            if (stack_r < min_stack_r) begin
              rc_nxt = RC_STACK;
            end else if (!p_valid) begin
              rc_nxt = RC_UNKNOWN;
            end else begin
              status_nxt[p_idx] = init_st;
              list_nxt[p_idx]   = 1'b0;
              mask_nxt[p_idx]   = (init_st == TS_READY);
              bank_op           = BK_CLEAR;
            end
          end
          OP_DELETE: begin
            if (prio_r == 3'd0) begin
              rc_nxt    = RC_IDLE;
              state_nxt = S_DONE;
            end else if (!p_valid) begin
              rc_nxt    = RC_UNKNOWN;
              state_nxt = S_DONE;
            end else begin
              status_nxt[p_idx] = TS_UNKNOWN;
              list_nxt[p_idx]   = 1'b0;
              mask_nxt[p_idx]   = 1'b0;
            end
          end
          OP_PEND: begin
            if (prio_r == 3'd0) begin
              rc_nxt    = RC_IDLE;
              state_nxt = S_DONE;
            end else if (!p_valid) begin
              rc_nxt    = RC_UNKNOWN;
              state_nxt = S_DONE;
            end else if (status_r[p_idx] == TS_UNKNOWN) begin
              rc_nxt    = RC_UNKNOWN;
              state_nxt = S_DONE;
            end else begin
              status_nxt[p_idx] = TS_PEND;
              list_nxt[p_idx]   = 1'b0;
              mask_nxt[p_idx]   = 1'b0;
            end
          end
          OP_READY: begin
            if (!p_valid) begin
              rc_nxt    = RC_UNKNOWN;
              state_nxt = S_DONE;
            end else if (status_r[p_idx] == TS_UNKNOWN) begin
              rc_nxt    = RC_UNKNOWN;
              state_nxt = S_DONE;
            end else if (status_r[p_idx] == TS_READY) begin
              rc_nxt    = RC_READY;
              state_nxt = S_DONE;
            end else begin
              status_nxt[p_idx] = TS_READY;
              list_nxt[p_idx]   = 1'b0;
              mask_nxt[p_idx]   = 1'b1;
              bank_op           = BK_CLEAR;
            end
          end
          OP_DELAY: begin
            // acts on the running task whatever its status
            bank_idx          = run_r;
            bank_op           = BK_LOAD;
            status_nxt[run_r] = TS_PEND;
            list_nxt[run_r]   = 1'b1;
            mask_nxt[run_r]   = 1'b0;
          end
          OP_TICK: begin
            idx_nxt   = '0;
            state_nxt = S_TICK;
          end
          default: begin
            rc_nxt    = RC_UNUSED;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_TICK: begin
        if (list_r[idx_r]) begin
          bank_op = BK_DEC;
          if (bank_zero) begin
            status_nxt[idx_r] = TS_READY;
            list_nxt[idx_r]   = 1'b0;
            mask_nxt[idx_r]   = 1'b1;
          end
        end
        if (idx_r == TOP_LVL) begin
          idx_nxt   = TOP_LVL;
          state_nxt = S_SCHED;
        end else begin
          idx_nxt = idx_r + LVL_W'(1);
        end
      end

      S_SCHED: begin
        // top-down scan, empty bitmap falls through to the idle level
        if (mask_r[idx_r] || idx_r == '0) begin
          run_nxt   = idx_r;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r - LVL_W'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = rc_r;
          out_prio_nxt  = 3'(run_r);
          out_bits_nxt  = 8'(mask_r);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int i = 0; i < PRIO_LEVELS; i++) begin
        status_r[i] <= TS_UNKNOWN;
      end
      list_r      <= '0;
      mask_r      <= '0;
      run_r       <= '0;
      idx_r       <= '0;
      rc_r        <= RC_OK;
      min_stack_r <= MIN_STACK_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      list_r      <= list_nxt;
      mask_r      <= mask_nxt;
      run_r       <= run_nxt;
      idx_r       <= idx_nxt;
      rc_r        <= rc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_stack_r <= cfg_wdata;
      end
    end
    out_code_r <= out_code_nxt;
    out_prio_r <= out_prio_nxt;
    out_bits_r <= out_bits_nxt;
    if (accept) begin
      op_r    <= opcode_t'(in_req.opcode);
      prio_r  <= in_req.task_prio;
      init_r  <= in_req.initial_state;
      stack_r <= in_req.stack_bytes;
      ticks_r <= DELAY_BITS'(in_req.delay_ticks);
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted request did not enter decode");

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, run_r} < (LVL_W + 1)'(PRIO_LEVELS)))
    else $error("running level beyond the level count");

  for (genvar g = 0; g < PRIO_LEVELS; g++) begin : g_chk
    a_mask_matches: assert property (@(posedge clk) disable iff (!rst_n)
      mask_r[g] == (status_r[g] == TS_READY))
      else $error("ready bit disagrees with task status");

    a_list_pended: assert property (@(posedge clk) disable iff (!rst_n)
      list_r[g] |-> (status_r[g] == TS_PEND))
      else $error("delayed task is not pended");
  end

endmodule
